// ===== rtl/bgf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgf_pkg
// Shared types, constants and helpers for the bilinear gradient fill block.
// ----------------------------------------------------------------------------
package bgf_pkg;

  localparam logic [11:0] MAX_WIDTH  = 12'd2048;
  localparam logic [11:0] MAX_HEIGHT = 12'd2048;

  localparam logic [31:0] PAIR_HI_MASK = 32'hff00ff00;

  // register indexes on the configuration port
  localparam logic [2:0] REG_CORNER_0     = 3'd0;
  localparam logic [2:0] REG_CORNER_1     = 3'd1;
  localparam logic [2:0] REG_CORNER_2     = 3'd2;
  localparam logic [2:0] REG_CORNER_3     = 3'd3;
  localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd4;
  localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd5;
  localparam logic [2:0] REG_BORDER_WIDTH = 3'd6;
  localparam logic [2:0] REG_BORDER_COLOR = 3'd7;

  typedef struct packed {
    logic [3:0][31:0] corner;
    logic [11:0]      width;
    logic [11:0]      height;
    logic [10:0]      border;
    logic [31:0]      border_color;
  } cfg_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [10:0] divisor;
  } div_req_t;

  // channel c (0 = R, byte 3) as 8.16 with half rounding bias
  function automatic logic [31:0] chan_start(input logic [31:0] col, input logic [1:0] c);
    logic [4:0] base;
    base = {~c, 3'b000};
    return {8'h00, col[base +: 8], 16'h8000};
  endfunction

  // integer parts of two 8.16 values packed into 8.8 pairs
  function automatic logic [31:0] pack_pair(input logic [31:0] hi, input logic [31:0] lo);
    return {hi[23:8], lo[23:8]};
  endfunction

endpackage

// ===== rtl/bgf_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgf_front
// Two-word input queue that decouples the input channel from the engine.
// ----------------------------------------------------------------------------
module bgf_front import bgf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic restart,
  output logic item_valid,
  output logic item_restart,
  input  logic item_pop
);

  logic [1:0] ent;
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  assign in_stall     = (count == 2'd2);
  assign push         = in_valid && !in_stall;
  assign item_valid   = (count != 2'd0);
  assign item_restart = ent[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr] <= restart;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (item_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, item_pop};
    end
  end

endmodule

// ===== rtl/bgf_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgf_div
// Serial signed divider: 32-bit dividend by 11-bit nonzero divisor,
// quotient truncated toward zero, one bit per cycle.
// ----------------------------------------------------------------------------
module bgf_div import bgf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  div_req_t    req,
  output logic        busy,
  output logic        done,
  output logic [31:0] quot
);

  logic        neg;
  logic [31:0] q;
  logic [10:0] rem;
  logic [10:0] dvs;
  logic [4:0]  cnt;
  logic [11:0] trial;
  logic        fits;

  assign trial = {rem, q[31]};
  assign fits  = trial >= {1'b0, dvs};
  assign quot  = neg ? (32'd0 - q) : q;

  always_ff @(posedge clk) begin
    if (req.start) begin
      neg <= req.dividend[31];
      q   <= req.dividend[31] ? (32'd0 - req.dividend) : req.dividend;
      rem <= 11'd0;
      dvs <= req.divisor;
    end else if (busy) begin
      // remainder stays below the divisor, so 11 bits hold it
      rem <= fits ? 11'(trial - {1'b0, dvs}) : trial[10:0];
      q   <= {q[30:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 5'd0;
    end else begin
      done <= busy && (cnt == 5'd31);
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 5'd0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== rtl/bgf_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgf_back
// Raster engine: frame and row setup through the shared divider, then one
// pixel per item into the output register.
// ----------------------------------------------------------------------------
module bgf_back import bgf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        item_valid,
  input  logic        item_restart,
  output logic        item_pop,
  output div_req_t    div_req,
  input  logic        div_done,
  input  logic [31:0] div_quot,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] pixel_value,
  output logic [10:0] pixel_x,
  output logic [10:0] pixel_y,
  output logic        frame_end
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_FDIV = 5'b00010,
    S_RDIV = 5'b00100,
    S_RSET = 5'b01000,
    S_PIX  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  logic [10:0] col_pos;
  logic [10:0] row_pos;
  logic [2:0]  idx;
  logic        issued;

  logic [3:0][31:0] la;
  logic [3:0][31:0] ra;
  logic [3:0][31:0] ls;
  logic [3:0][31:0] rs;
  logic [3:0][31:0] rowd;
  logic [31:0] rb_acc;
  logic [31:0] ga_acc;
  logic [31:0] rb_step;
  logic [31:0] ga_step;
  logic        rb_sub;
  logic        ga_sub;

  logic [11:0] w;
  logic [11:0] h;
  logic [11:0] b2;
  logic        inner;
  logic [11:0] iw;
  logic [11:0] ih;
  logic [11:0] w_m_b;
  logic [11:0] h_m_b;
  logic [10:0] x_sel;
  logic [10:0] y_sel;
  logic        row_in;
  logic        col_in;
  logic        last_col;
  logic        last_row;
  logic        out_free;
  logic        in_div;
  logic [10:0] divisor;
  logic        div_last;
  logic [31:0] dr;
  logic [31:0] dg;
  logic [31:0] db;
  logic [31:0] da;

  always_comb begin
    if (cfg.width == 12'd0) w = 12'd1;
    else if (cfg.width > MAX_WIDTH) w = MAX_WIDTH;
    else w = cfg.width;
    if (cfg.height == 12'd0) h = 12'd1;
    else if (cfg.height > MAX_HEIGHT) h = MAX_HEIGHT;
    else h = cfg.height;
  end

  assign b2    = {cfg.border, 1'b0};
  assign inner = (b2 < w) && (b2 < h);
  assign iw    = inner ? (w - b2) : 12'd1;
  assign ih    = inner ? (h - b2) : 12'd1;
  assign w_m_b = w - {1'b0, cfg.border};
  assign h_m_b = h - {1'b0, cfg.border};

  assign x_sel = (state == S_IDLE && item_restart) ? 11'd0 : col_pos;
  assign y_sel = (state == S_IDLE && item_restart) ? 11'd0 : row_pos;

  assign row_in   = inner && ({1'b0, y_sel} >= {1'b0, cfg.border}) && ({1'b0, y_sel} < h_m_b);
  assign col_in   = ({1'b0, x_sel} >= {1'b0, cfg.border}) && ({1'b0, x_sel} < w_m_b);
  assign last_col = {1'b0, x_sel} >= (w - 12'd1);
  assign last_row = {1'b0, y_sel} >= (h - 12'd1);

  assign out_free = !out_valid || !out_stall;
  assign item_pop = (state == S_IDLE) && item_valid;
  assign in_div   = (state == S_FDIV) || (state == S_RDIV);
  assign divisor  = (state == S_FDIV) ? 11'(ih - 12'd1) : 11'(iw - 12'd1);
  assign div_last = (state == S_FDIV) ? (idx == 3'd7) : (idx == 3'd3);

  always_comb begin
    div_req.start    = in_div && !issued && (divisor != 11'd0);
    div_req.divisor  = divisor;
    div_req.dividend = ra[idx[1:0]] - la[idx[1:0]];
    if (state == S_FDIV) begin
      div_req.dividend = idx[0]
        ? chan_start(cfg.corner[3], idx[2:1]) - chan_start(cfg.corner[1], idx[2:1])
        : chan_start(cfg.corner[2], idx[2:1]) - chan_start(cfg.corner[0], idx[2:1]);
    end
  end

  // keep the blue and alpha steps non-negative
  always_comb begin
    rb_sub = rowd[2][31];
    ga_sub = rowd[3][31];
    dr = rb_sub ? (32'd0 - rowd[0]) : rowd[0];
    db = rb_sub ? (32'd0 - rowd[2]) : rowd[2];
    dg = ga_sub ? (32'd0 - rowd[1]) : rowd[1];
    da = ga_sub ? (32'd0 - rowd[3]) : rowd[3];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          if (x_sel == 11'd0 && y_sel == 11'd0) state_next = S_FDIV;
          else if (row_in && x_sel == 11'd0) state_next = S_RDIV;
          else state_next = S_PIX;
        end
      end
      S_FDIV: begin
        if ((divisor == 11'd0 || (issued && div_done)) && div_last) begin
          state_next = (row_in && col_pos == 11'd0) ? S_RDIV : S_PIX;
        end
      end
      S_RDIV: begin
        if ((divisor == 11'd0 || (issued && div_done)) && div_last) state_next = S_RSET;
      end
      S_RSET: state_next = S_PIX;
      S_PIX: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      col_pos   <= 11'd0;
      row_pos   <= 11'd0;
      idx       <= 3'd0;
      issued    <= 1'b0;
      out_valid <= 1'b0;
      la <= '0; ra <= '0; ls <= '0; rs <= '0; rowd <= '0;
      rb_acc <= 32'd0; ga_acc <= 32'd0; rb_step <= 32'd0; ga_step <= 32'd0;
    end else begin
      state <= state_next;
      if (state == S_PIX && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            col_pos <= x_sel;
            row_pos <= y_sel;
            idx     <= 3'd0;
            if (x_sel == 11'd0 && y_sel == 11'd0) begin
              for (int c = 0; c < 4; c++) begin
                la[c] <= chan_start(cfg.corner[0], 2'(c));
                ra[c] <= chan_start(cfg.corner[1], 2'(c));
              end
            end
          end
        end
        S_FDIV, S_RDIV: begin
          if (divisor == 11'd0 || (issued && div_done)) begin
            // unit length gives a zero step
            if (state == S_FDIV) begin
              if (idx[0]) rs[idx[2:1]] <= (divisor == 11'd0) ? 32'd0 : div_quot;
              else ls[idx[2:1]] <= (divisor == 11'd0) ? 32'd0 : div_quot;
            end else begin
              rowd[idx[1:0]] <= (divisor == 11'd0) ? 32'd0 : div_quot;
            end
            issued <= 1'b0;
            idx    <= div_last ? 3'd0 : idx + 3'd1;
          end else if (div_req.start) begin
            issued <= 1'b1;
          end
        end
        S_RSET: begin
          rb_acc  <= pack_pair(la[0], la[2]);
          ga_acc  <= pack_pair(la[1], la[3]);
          rb_step <= pack_pair(dr, db);
          ga_step <= pack_pair(dg, da);
        end
        S_PIX: begin
          if (out_free) begin
            if (row_in && col_in) begin
              rb_acc <= rb_sub ? rb_acc - rb_step : rb_acc + rb_step;
              ga_acc <= ga_sub ? ga_acc - ga_step : ga_acc + ga_step;
            end
            if (row_in && last_col) begin
              for (int c = 0; c < 4; c++) begin
                la[c] <= la[c] + ls[c];
                ra[c] <= ra[c] + rs[c];
              end
            end
            if (last_col) begin
              col_pos <= 11'd0;
              row_pos <= last_row ? 11'd0 : row_pos + 11'd1;
            end else begin
              col_pos <= col_pos + 11'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (state == S_PIX && out_free) begin
      pixel_value <= (row_in && col_in)
        ? ((rb_acc & PAIR_HI_MASK) | ((ga_acc & PAIR_HI_MASK) >> 8))
        : cfg.border_color;
      pixel_x   <= col_pos;
      pixel_y   <= row_pos;
      frame_end <= last_col && last_row;
    end
  end

endmodule

// ===== rtl/bilinear_gradient_fill.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_gradient_fill
// Raster generator of a bilinear corner gradient inside a border ring.
// ----------------------------------------------------------------------------
// Usage:
//   Each word on the input channel (in_valid / in_stall, field restart)
//   yields one pixel word on the output channel (out_valid / out_stall):
//   pixel_value at (pixel_x, pixel_y), frame_end on the last pixel.
//   restart = 1 jumps to the top-left pixel and sets up a fresh frame.
//   The user writes the registers on the cfg port (cfg_valid / cfg_ready,
//   cfg_index, cfg_data) only while no pixel is pending; the block itself
//   does not enforce this, and cfg_ready is always high. Setup uses one
//   serial divider: a frame start adds up to 8 divisions, and the first
//   column of each interior row adds up to 4 divisions and a row setup
//   step. A two-word input queue lets requests queue up during setup.
// Reset clears position, setup state and the queues; the registers return
// to width 1, height 1 and zero elsewhere. A stalled output holds its word
// and the engine waits with the next pixel until the register frees up.
// ----------------------------------------------------------------------------
module bilinear_gradient_fill import bgf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        restart,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] pixel_value,
  output logic [10:0] pixel_x,
  output logic [10:0] pixel_y,
  output logic        frame_end,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_t        cfg;
  logic        item_valid;
  logic        item_restart;
  logic        item_pop;
  div_req_t    div_req;
  logic        div_busy;
  logic        div_done;
  logic [31:0] div_quot;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.corner       <= '0;
      cfg.width        <= 12'd1;
      cfg.height       <= 12'd1;
      cfg.border       <= 11'd0;
      cfg.border_color <= 32'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CORNER_0:     cfg.corner[0]     <= cfg_data;
        REG_CORNER_1:     cfg.corner[1]     <= cfg_data;
        REG_CORNER_2:     cfg.corner[2]     <= cfg_data;
        REG_CORNER_3:     cfg.corner[3]     <= cfg_data;
        REG_IMAGE_WIDTH:  cfg.width         <= cfg_data[11:0];
        REG_IMAGE_HEIGHT: cfg.height        <= cfg_data[11:0];
        REG_BORDER_WIDTH: cfg.border        <= cfg_data[10:0];
        REG_BORDER_COLOR: cfg.border_color  <= cfg_data;
        default: ;
      endcase
    end
  end

  bgf_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .restart      (restart),
    .item_valid   (item_valid),
    .item_restart (item_restart),
    .item_pop     (item_pop)
  );

  bgf_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .busy (div_busy),
    .done (div_done),
    .quot (div_quot)
  );

  bgf_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .item_valid   (item_valid),
    .item_restart (item_restart),
    .item_pop     (item_pop),
    .div_req      (div_req),
    .div_done     (div_done),
    .div_quot     (div_quot),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pixel_value  (pixel_value),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .frame_end    (frame_end)
  );

  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_busy)
    else $error("divider started while busy");

  a_div_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    div_done |-> ($past(div_busy) && !div_busy))
    else $error("divider done without a finished run");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    item_pop |-> item_valid)
    else $error("queue popped while empty");

endmodule
